// ===== src/vst_pkg.sv =====
// Package for the vertex-to-screen transform: payload types, register codes,
// shared constants. No dependencies.
package vst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int SIZE_W = 13;
  localparam int DIV_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_SECOND = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_FIRST  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_SECOND = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_FIRST  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_SECOND = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 4'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_WZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
  } vert_t;

  typedef struct packed {
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic [1:0]         status;
  } pixel_t;

  // clamp a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                 output logic sat);
    logic signed [31:0] r;
    sat = 1'b0;
    r = v[31:0];
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      r = S32_MAX;
    end else if (v < -66'sd2147483648) begin
      sat = 1'b1;
      r = S32_MIN;
    end
    return r;
  endfunction

endpackage

// ===== src/vertex_to_screen_transform_unit.sv =====
// Vertex-to-screen transform unit: matrix rows, perspective divide, viewport.
// Depends on vst_pkg, vst_divider, vst_div_stage.
//
// One vertex is taken per clock and one pixel result leaves per clock when
// downstream is ready. The stages in order: one multiply stage, one row sum
// stage, a clamp stage, 64 stages of the bit-per-stage divider for x and y,
// one viewport multiply stage, then the output register, which also takes the
// halved and clamped pixel. The whole pipe advances together; it holds when
// the output register is full and not taken.
module vertex_to_screen_transform_unit #(
  parameter int FRAC_BITS = vst_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vst_pkg::vert_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vst_pkg::pixel_t                   out_data,
  input  logic                              cfg_we,
  input  logic [vst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vst_pkg::*;

  logic [63:0] regs [6];
  logic [SIZE_W-1:0] scr_w, scr_h;
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'(1) << FRAC_BITS;
      regs[1] <= '0;
      regs[2] <= (64'(1) << FRAC_BITS) << 32;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= (64'(1) << FRAC_BITS) << 32;
      scr_w   <= 13'd640;
      scr_h   <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X_FIRST:  regs[0] <= cfg_data;
        REG_ROW_X_SECOND: regs[1] <= cfg_data;
        REG_ROW_Y_FIRST:  regs[2] <= cfg_data;
        REG_ROW_Y_SECOND: regs[3] <= cfg_data;
        REG_ROW_W_FIRST:  regs[4] <= cfg_data;
        REG_ROW_W_SECOND: regs[5] <= cfg_data;
        REG_SCREEN_W:     scr_w   <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_H:     scr_h   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: nine 32x32 products
  logic               v1;
  logic signed [63:0] p1 [3][3];
  logic signed [31:0] t1 [3];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p1[r][0] <= $signed(regs[2*r][31:0]) * in_data.vert_x;
        p1[r][1] <= $signed(regs[2*r][63:32]) * in_data.vert_y;
        p1[r][2] <= $signed(regs[2*r+1][31:0]) * in_data.vert_z;
        t1[r]    <= $signed(regs[2*r+1][63:32]);
      end
    end
  end

  // stage 2: exact row sums, then floor shift and translation
  logic               v2;
  logic signed [65:0] s2 [3];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s2[r] <= ((66'(p1[r][0]) + 66'(p1[r][1]) + 66'(p1[r][2])) >>> FRAC_BITS)
                 + 66'(t1[r]);
      end
    end
  end

  // stage 3: clamp clip values
  logic               v3;
  logic signed [31:0] c3 [3];
  logic               sat3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    logic s0, s1, s2b;
    if (en) begin
      c3[0] <= clamp32(s2[0], s0);
      c3[1] <= clamp32(s2[1], s1);
      c3[2] <= clamp32(s2[2], s2b);
      sat3  <= s0 | s1 | s2b;
    end
  end

  // dividers; sideband: wzero, sign x, sign y, sat
  localparam int SIDE_W = 4;
  logic [SIDE_W-1:0]  side3;
  logic signed [31:0] den3;
  logic               wz3;
  assign wz3   = (c3[2] == 32'sd0);
  assign den3  = wz3 ? 32'sd1 : c3[2];
  assign side3 = {wz3, c3[0][31], c3[1][31], sat3};

  logic               vdx, vdy;
  logic signed [65:0] qx, qy;
  logic [SIDE_W-1:0]  sdx, sdy;

  vst_divider #(.SIDE_W(SIDE_W)) u_div_x (
    .clk, .rst, .en, .in_valid(v3),
    .num(64'(c3[0]) <<< FRAC_BITS), .den(den3), .in_side(side3),
    .out_valid(vdx), .quo(qx), .out_side(sdx)
  );
  vst_divider #(.SIDE_W(SIDE_W)) u_div_y (
    .clk, .rst, .en, .in_valid(v3),
    .num(64'(c3[1]) <<< FRAC_BITS), .den(den3), .in_side(side3),
    .out_valid(vdy), .quo(qy), .out_side(sdy)
  );

  // stage A: clamp ndc, multiply by screen size
  logic               va;
  logic signed [47:0] ma_x, ma_y;
  logic [SIDE_W-1:0]  sa;
  logic               sata;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vdx & vdy;
  end
  always_ff @(posedge clk) begin
    logic ax, ay;
    logic signed [31:0] nx, ny;
    if (en) begin
      nx = clamp32(qx, ax);
      ny = clamp32(qy, ay);
      ma_x <= (48'(nx) + (48'sd1 <<< FRAC_BITS)) * $signed({1'b0, scr_w});
      ma_y <= (48'(ny) + (48'sd1 <<< FRAC_BITS)) * $signed({1'b0, scr_h});
      sa   <= sdx;
      sata <= ax | ay;
    end
  end

  // stage B: halve, clamp, pick the result
  pixel_t res;
  always_comb begin
    logic bx, by;
    logic signed [31:0] hx, hy;
    hx = clamp32(66'(ma_x >>> 1), bx);
    hy = clamp32(66'(ma_y >>> 1), by);
    if (sa[3]) begin
      res.pixel_x = sa[2] ? S32_MIN : S32_MAX;
      res.pixel_y = sa[1] ? S32_MIN : S32_MAX;
      res.status  = ST_WZ;
    end else begin
      res.pixel_x = hx;
      res.pixel_y = hy;
      res.status  = (sa[0] | sata | bx | by) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= va;
  end
  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end
endmodule

// ===== src/vst_div_stage.sv =====
// One radix-2 step of a restoring unsigned divider, pipelined.
// Depends on vst_pkg. Carries sideband data with the quotient.
module vst_div_stage #(
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [vst_pkg::DIV_W-1:0]   in_rem,
  input  logic [vst_pkg::DIV_W-1:0]   in_quo,
  input  logic [vst_pkg::DIV_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [vst_pkg::DIV_W-1:0]   out_rem,
  output logic [vst_pkg::DIV_W-1:0]   out_quo,
  output logic [vst_pkg::DIV_W-1:0]   out_den,
  output logic [SIDE_W-1:0]           out_side
);
  import vst_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] rem_sh;

  // shift in the next dividend bit, try to subtract
  always_comb begin
    rem_sh = {in_rem[DIV_W-2:0], in_quo[DIV_W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_side <= in_side;
      if (!trial[DIV_W] || in_rem[DIV_W-1]) begin
        out_rem <= trial[DIV_W-1:0];
        out_quo <= {in_quo[DIV_W-2:0], 1'b1};
      end else begin
        out_rem <= rem_sh;
        out_quo <= {in_quo[DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== src/vst_divider.sv =====
// Pipelined signed divider: trunc(num / den), one quotient bit per stage.
// Depends on vst_pkg and vst_div_stage.
module vst_divider #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [63:0]         num,
  input  logic signed [31:0]         den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic signed [65:0]         quo,
  output logic [SIDE_W-1:0]          out_side
);
  import vst_pkg::*;

  localparam int SW = SIDE_W + 1;

  logic [DIV_W-1:0] rem_a [DIV_W+1];
  logic [DIV_W-1:0] quo_a [DIV_W+1];
  logic [DIV_W-1:0] den_a [DIV_W+1];
  logic [SW-1:0]    side_a [DIV_W+1];
  logic             vld_a [DIV_W+1];
  logic [63:0]      num_mag;
  logic [63:0]      den_mag;
  logic             neg;
  logic [DIV_W-1:0] qm;

  // magnitudes and result sign
  always_comb begin
    num_mag = num[63] ? 64'(-num) : 64'(num);
    den_mag = den[31] ? 64'(-{{32{den[31]}}, den}) : 64'({{32{den[31]}}, den});
    neg     = num[63] ^ den[31];
  end

  assign rem_a[0]  = '0;
  assign quo_a[0]  = num_mag;
  assign den_a[0]  = den_mag;
  assign side_a[0] = {neg, in_side};
  assign vld_a[0]  = in_valid;

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    vst_div_stage #(.SIDE_W(SW)) u_stage (
      .clk, .rst, .en,
      .in_valid(vld_a[i]), .in_rem(rem_a[i]), .in_quo(quo_a[i]),
      .in_den(den_a[i]), .in_side(side_a[i]),
      .out_valid(vld_a[i+1]), .out_rem(rem_a[i+1]), .out_quo(quo_a[i+1]),
      .out_den(den_a[i+1]), .out_side(side_a[i+1])
    );
  end

  assign qm        = quo_a[DIV_W];
  assign out_valid = vld_a[DIV_W];
  assign out_side  = side_a[DIV_W][SIDE_W-1:0];
  assign quo = side_a[DIV_W][SIDE_W] ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
endmodule

// ===== test/tb_top.sv =====
// Testbench for vertex_to_screen_transform_unit: matrix transform, divide, viewport.
// Depends on vst_pkg and the unit RTL; a self-contained predictor checks every result.
`timescale 1ns / 1ps

module tb_top;
  import vst_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vert_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pixel_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vertex_to_screen_transform_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the unit's registers
  logic [63:0] mat_regs [8];
  vert_t pending_verts [$];
  pixel_t expected_pixels [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int errors = 0;

  function automatic longint clamp_s32(logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return longint'(v);
  endfunction

  // one matrix row dot (x, y, z, 1), floored once, then clamped
  function automatic longint row_clip(int r, vert_t v, inout logic sat);
    logic signed [127:0] acc;
    acc = $signed(mat_regs[r][31:0]) * v.vert_x + $signed(mat_regs[r][63:32]) * v.vert_y
        + $signed(mat_regs[r+1][31:0]) * v.vert_z;
    acc = (acc >>> FB) + $signed(mat_regs[r+1][63:32]);
    return clamp_s32(acc, sat);
  endfunction

  function automatic longint ndc_to_pixel(longint c, longint w, logic [12:0] size,
                                          inout logic sat);
    longint ndc;
    logic signed [127:0] t;
    t = (c * ONE) / w;
    ndc = clamp_s32(t, sat);
    t = (ndc + ONE) * longint'(size);
    return clamp_s32(t >>> 1, sat);
  endfunction

  function automatic pixel_t transform_vertex(vert_t v);
    logic sat;
    longint cx, cy, cw;
    pixel_t r;
    sat = 1'b0;
    cx = row_clip(0, v, sat);
    cy = row_clip(2, v, sat);
    cw = row_clip(4, v, sat);
    if (cw == 0) begin
      r.pixel_x = (cx >= 0) ? S32_MAX : S32_MIN;
      r.pixel_y = (cy >= 0) ? S32_MAX : S32_MIN;
      r.status = ST_WZ;
    end else begin
      r.pixel_x = 32'(ndc_to_pixel(cx, cw, mat_regs[6][12:0], sat));
      r.pixel_y = 32'(ndc_to_pixel(cy, cw, mat_regs[7][12:0], sat));
      r.status = sat ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_verts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_verts.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 600;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accept, compare on delivery
  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst) begin
      if (in_valid && in_ready) expected_pixels.push_back(transform_vertex(in_data));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing expected: %h", out_data);
          errors++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_data.pixel_x !== exp_px.pixel_x) begin
            $error("pixel_x expected %h got %h", exp_px.pixel_x, out_data.pixel_x);
            errors++;
          end
          if (out_data.pixel_y !== exp_px.pixel_y) begin
            $error("pixel_y expected %h got %h", exp_px.pixel_y, out_data.pixel_y);
            errors++;
          end
          if (out_data.status !== exp_px.status) begin
            $error("status expected %0d got %0d", exp_px.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < 8) mat_regs[idx] = (idx >= REG_SCREEN_W) ? (val & 64'h1FFF) : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(logic [31:0] m00, m01, m02, m03, m10, m11, m12, m13,
                            m30, m31, m32, m33, logic [63:0] w, h);
    write_reg(REG_ROW_X_FIRST, {m01, m00});
    write_reg(REG_ROW_X_SECOND, {m03, m02});
    write_reg(REG_ROW_Y_FIRST, {m11, m10});
    write_reg(REG_ROW_Y_SECOND, {m13, m12});
    write_reg(REG_ROW_W_FIRST, {m31, m30});
    write_reg(REG_ROW_W_SECOND, {m33, m32});
    write_reg(REG_SCREEN_W, w);
    write_reg(REG_SCREEN_H, h);
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    wait (pending_verts.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  // mostly small coordinates, some full-range and some extremes
  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
    if (sel < 8) return $urandom;
    case ($urandom_range(3))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return 32'hffffffff;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(7) == 0) return $urandom;
    return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
  endfunction

  task automatic queue_random(int n);
    vert_t v;
    repeat (n) begin
      v.vert_x = rand_coord();
      v.vert_y = rand_coord();
      v.vert_z = rand_coord();
      pending_verts.push_back(v);
    end
  endtask

  initial begin
    vert_t v;
    logic [31:0] edges [6];
    edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
              32'h00010000, 32'hffff0000};
    mat_regs[0] = 64'd65536;
    mat_regs[1] = 64'd0;
    mat_regs[2] = 64'd65536 << 32;
    mat_regs[3] = 64'd0;
    mat_regs[4] = 64'd0;
    mat_regs[5] = 64'd65536 << 32;
    mat_regs[6] = 64'd640;
    mat_regs[7] = 64'd480;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes on the reset matrix
    foreach (edges[i]) begin
      v.vert_x = edges[i];
      v.vert_y = edges[5 - i];
      v.vert_z = edges[(i + 2) % 6];
      pending_verts.push_back(v);
    end
    drain();

    // directed: zero clip w with mixed signs of x and y, plus an ignored index
    write_reg(4'd9, 64'h0);
    load_setup(32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0);
    foreach (edges[i]) begin
      v.vert_x = edges[i];
      v.vert_y = edges[(i + 3) % 6];
      v.vert_z = (i < 3) ? 32'h0 : 32'h10000;
      pending_verts.push_back(v);
    end
    drain();

    // directed: all-ones x row, extreme y row, maximal screen width, oversized height value
    load_setup('1, '1, '1, '1, 32'h7fffffff, 32'h80000000, '1, 32'h7fffffff,
               32'h1, 0, 0, 32'h1, 64'd8191, 64'hFFFF_FFFF_FFFF_F001);
    foreach (edges[i]) begin
      v.vert_x = edges[i];
      v.vert_y = edges[i];
      v.vert_z = edges[5 - i];
      pending_verts.push_back(v);
    end
    drain();

    // random phases across idling modes and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        0: load_setup(32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'hffff0000, 32'h0,
                      64'd1, 64'd4096);
        1: load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef(), rand_coef(), 0, 0, 0, 0, 64'd0, 64'd4096);
        5: load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef(), rand_coef(), $urandom, $urandom, $urandom,
                      $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        default: load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef(), rand_coef(), 64'($urandom_range(1, 4096)),
                            64'($urandom_range(1, 4096)));
      endcase
      // long output hold-off while requests keep coming
      if (ph == 0) hold_req = 1'b1;
      queue_random(175);
      drain();
    end

    if (errors == 0) begin
      $display("vertex_to_screen_transform_unit regression: pass");
    end else begin
      $display("vertex_to_screen_transform_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("vertex_to_screen_transform_unit regression: fail");
    $finish;
  end

endmodule
